/* hw/rtl/fse_pkg.sv */
// ----------------------------------------------------------------------------
// Floor sum engine package
// Shared types and constants for the floor sum engine and its divider.
// ----------------------------------------------------------------------------
package fse_pkg;

    localparam int unsigned SLOPE_W = 24;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned TOTAL_W = 64;
    localparam int unsigned CNT_W   = 6;

    // Dividend width selector for the shared divider
    typedef enum logic [1:0] {
        DIV_W24,
        DIV_W32,
        DIV_W57
    } t_div_op;

    typedef struct packed {
        logic    start;
        t_div_op op;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [TOTAL_W-1:0] quo;
        logic [SLOPE_W-1:0] rem;
    } t_div_rsp;

    // Number of quotient bits produced for each dividend width
    function automatic logic [CNT_W-1:0] div_len(input t_div_op op);
        logic [CNT_W-1:0] len;
        case (op)
            DIV_W24: len = CNT_W'(24);
            DIV_W32: len = CNT_W'(32);
            DIV_W57: len = CNT_W'(57);
            default: len = CNT_W'(32);
        endcase
        return len;
    endfunction

endpackage

/* hw/rtl/fse_div.sv */
// ----------------------------------------------------------------------------
// Floor sum divider
// Restoring radix-2 divider, one quotient bit per cycle, 24-bit divisor.
// ----------------------------------------------------------------------------
module fse_div import fse_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    input  logic [TOTAL_W-1:0] i_dividend,
    input  logic [SLOPE_W-1:0] i_divisor,
    output t_div_rsp           o_rsp
);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [TOTAL_W-1:0] r_num;
    logic [SLOPE_W-1:0] r_rem;
    logic [SLOPE_W-1:0] r_den;

    logic [TOTAL_W-1:0] aligned;
    logic [SLOPE_W:0]   trial;
    logic               ge;
    logic [SLOPE_W:0]   diff;

    // Left-align the dividend so its top bit enters first
    always_comb begin
        case (i_req.op)
            DIV_W24: aligned = {i_dividend[23:0], 40'd0};
            DIV_W32: aligned = {i_dividend[31:0], 32'd0};
            DIV_W57: aligned = {i_dividend[56:0], 7'd0};
            default: aligned = {i_dividend[31:0], 32'd0};
        endcase
    end

    assign trial = {r_rem, r_num[TOTAL_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= div_len(i_req.op) - CNT_W'(1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift into the low end of r_num
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= aligned;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[TOTAL_W-2:0], ge};
            r_rem <= ge ? diff[SLOPE_W-1:0] : trial[SLOPE_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num;
    assign o_rsp.rem  = r_rem;

endmodule

/* hw/rtl/floor_sum_engine_unit.sv */
// ----------------------------------------------------------------------------
// Floor sum engine
// Sum over i = 0..n of floor((a*i + b) / c), modulo 2^64, by the
// Euclidean-like reduction on a shared divider and a shared multiplier.
// ----------------------------------------------------------------------------
// Run time: a zero divisor gives the result straight from the check state,
//   with no division; otherwise it grows with the number of reduction and
//   reflection rounds plus a final round, each of which waits on the
//   bit-serial divider for 24, 32 or 57 quotient bits per division.
// Throughput: one request at a time; busy stays high until the result strobe.
// The result is shown for one cycle with o_valid; the receiver cannot stall.
// Reset: i_rst_n is synchronous, active low; it returns the sequencer to idle,
//   stops the divider and drops o_valid.
// ----------------------------------------------------------------------------
module floor_sum_engine_unit import fse_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [SLOPE_W-1:0] i_slope,
    input  logic [WORD_W-1:0]  i_offset,
    input  logic [SLOPE_W-1:0] i_divisor,
    input  logic [WORD_W-1:0]  i_last_index,
    output logic               o_valid,
    output logic [TOTAL_W-1:0] o_floor_total
);

    // Sequencer states, grouped by path:
    //   Z_* closes a zero-slope round, R_* takes the quotients out,
    //   F_* reflects the sum (swap slope and divisor, flip the sign).
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_Z_DIV,
        S_Z_MUL,
        S_Z_ACC,
        S_R_DIVA,
        S_R_DIVB,
        S_R_TRI,
        S_R_LO,
        S_R_HI,
        S_R_HIACC,
        S_R_NB,
        S_R_NBACC,
        S_F_MUL,
        S_F_ADD,
        S_F_DIV
    } t_state;

    t_state             r_state;
    logic               r_valid;
    logic [TOTAL_W-1:0] r_result;

    // Working set of the reduction
    logic [SLOPE_W-1:0] r_a;
    logic [WORD_W-1:0]  r_b;
    logic [SLOPE_W-1:0] r_c;
    logic [WORD_W-1:0]  r_n;
    logic               r_neg;
    logic [TOTAL_W-1:0] r_total;

    // Quotients, remainders and products
    logic [SLOPE_W-1:0] r_qa;
    logic [SLOPE_W-1:0] r_ra;
    logic [WORD_W-1:0]  r_qb;
    logic [SLOPE_W-1:0] r_rb;
    logic [WORD_W-1:0]  r_top;
    logic [TOTAL_W-1:0] r_tri;
    logic [TOTAL_W-1:0] r_prod;

    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic [TOTAL_W-1:0] div_dividend;

    logic [WORD_W-1:0]  mul_x;
    logic [WORD_W-1:0]  mul_y;
    logic [WORD_W-1:0]  tri_x;
    logic [WORD_W-1:0]  tri_y;
    logic [TOTAL_W-1:0] acc_add;
    logic [TOTAL_W-1:0] acc_total;
    logic               need_reduce;
    logic               top_zero;

    // ------------------------------------------------------------------
    // Shared divider
    // ------------------------------------------------------------------
    fse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (r_c),
        .o_rsp      (div_rsp)
    );

    assign need_reduce = (r_a >= r_c) || (r_b >= WORD_W'(r_c));
    assign top_zero    = (div_rsp.quo == '0);

    // Issue divisions: a/c and b/c for a reduction, b/c for a zero slope,
    // (a*n + b)/c for a reflection.
    always_comb begin
        div_req.start = 1'b0;
        div_req.op    = DIV_W32;
        div_dividend  = TOTAL_W'(r_b);
        case (r_state)
            S_CHECK: begin
                if (r_c != '0) begin
                    if (r_a == '0) begin
                        div_req.start = 1'b1;
                    end else if (need_reduce) begin
                        div_req.start = 1'b1;
                        div_req.op    = DIV_W24;
                        div_dividend  = TOTAL_W'(r_a);
                    end
                end
            end
            S_R_DIVA: begin
                div_req.start = div_rsp.done;
            end
            S_F_ADD: begin
                div_req.start = 1'b1;
                div_req.op    = DIV_W57;
                div_dividend  = TOTAL_W'(r_prod[56:0]) + TOTAL_W'(r_b);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Shared 32x32 multiplier, product registered every cycle
    // ------------------------------------------------------------------
    // n*(n+1)/2 as one product: halve whichever factor is even.
    assign tri_x = r_n[0] ? r_n : (r_n >> 1);
    assign tri_y = r_n[0] ? ((r_n >> 1) + WORD_W'(1)) : (r_n + WORD_W'(1));

    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (r_state)
            S_Z_MUL, S_R_NB: begin
                mul_x = r_n;
                mul_y = r_qb;
            end
            S_R_TRI: begin
                mul_x = tri_x;
                mul_y = tri_y;
            end
            S_R_LO: begin
                mul_x = r_prod[31:0];
                mul_y = WORD_W'(r_qa);
            end
            S_R_HI: begin
                mul_x = r_tri[63:32];
                mul_y = WORD_W'(r_qa);
            end
            S_F_MUL: begin
                mul_x = WORD_W'(r_a);
                mul_y = r_n;
            end
            S_F_ADD: begin
                mul_x = '0;
                mul_y = '0;
            end
            default: begin
                // Reflection term n*top once the quotient is in r_top
                mul_x = r_n;
                mul_y = r_top;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= TOTAL_W'(mul_x) * TOTAL_W'(mul_y);
    end

    // ------------------------------------------------------------------
    // Signed accumulation modulo 2^64
    // ------------------------------------------------------------------
    // (n+1)*q is taken as n*q + q so that every factor fits 32 bits.
    always_comb begin
        case (r_state)
            S_Z_ACC, S_R_NBACC: acc_add = r_prod + TOTAL_W'(r_qb);
            S_R_HI:             acc_add = r_prod;
            S_R_HIACC:          acc_add = {r_prod[31:0], 32'd0};
            S_F_DIV:            acc_add = r_prod;
            default:            acc_add = '0;
        endcase
    end

    assign acc_total = r_neg ? (r_total - acc_add) : (r_total + acc_add);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    // S_F_DIV doubles as the reflection accumulate step: after the quotient
    // lands in r_top it stays in the state while r_mul_wait marks the cycle
    // that forms n*top, and r_refl_acc the cycle that adds it.
    logic r_refl_acc;
    logic r_mul_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= 1'b0;
            r_refl_acc <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_a     <= i_slope;
                        r_b     <= i_offset;
                        r_c     <= i_divisor;
                        r_n     <= i_last_index;
                        r_neg   <= 1'b0;
                        r_total <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_c == '0) begin
                        // Zero divisor: result is zero
                        r_result <= '0;
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_a == '0) begin
                        r_state <= S_Z_DIV;
                    end else if (need_reduce) begin
                        r_state <= S_R_DIVA;
                    end else begin
                        r_state <= S_F_MUL;
                    end
                end
                S_Z_DIV: begin
                    if (div_rsp.done) begin
                        r_qb    <= div_rsp.quo[31:0];
                        r_state <= S_Z_MUL;
                    end
                end
                S_Z_MUL: begin
                    r_state <= S_Z_ACC;
                end
                S_Z_ACC: begin
                    r_total  <= acc_total;
                    r_result <= acc_total;
                    r_valid  <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_R_DIVA: begin
                    if (div_rsp.done) begin
                        r_qa    <= div_rsp.quo[23:0];
                        r_ra    <= div_rsp.rem;
                        r_state <= S_R_DIVB;
                    end
                end
                S_R_DIVB: begin
                    if (div_rsp.done) begin
                        r_qb    <= div_rsp.quo[31:0];
                        r_rb    <= div_rsp.rem;
                        r_state <= S_R_TRI;
                    end
                end
                S_R_TRI: begin
                    r_state <= S_R_LO;
                end
                S_R_LO: begin
                    // Hold the triangle number while its low half is scaled
                    r_tri   <= r_prod;
                    r_state <= S_R_HI;
                end
                S_R_HI: begin
                    r_total <= acc_total;
                    r_state <= S_R_HIACC;
                end
                S_R_HIACC: begin
                    r_total <= acc_total;
                    r_state <= S_R_NB;
                end
                S_R_NB: begin
                    r_state <= S_R_NBACC;
                end
                S_R_NBACC: begin
                    r_total <= acc_total;
                    r_a     <= r_ra;
                    r_b     <= WORD_W'(r_rb);
                    r_state <= S_CHECK;
                end
                S_F_MUL: begin
                    r_state <= S_F_ADD;
                end
                S_F_ADD: begin
                    r_refl_acc <= 1'b0;
                    r_state    <= S_F_DIV;
                end
                S_F_DIV: begin
                    if (r_refl_acc) begin
                        // Add n*top, then swap roles and flip the sign
                        r_refl_acc <= 1'b0;
                        r_total    <= acc_total;
                        r_neg      <= ~r_neg;
                        r_a        <= r_c;
                        r_c        <= r_a;
                        r_b        <= WORD_W'(r_c - r_b[SLOPE_W-1:0] - SLOPE_W'(1));
                        r_n        <= r_top - WORD_W'(1);
                        r_state    <= S_CHECK;
                    end else if (r_mul_wait) begin
                        // n*top is formed this cycle; add it on the next
                        r_refl_acc <= 1'b1;
                    end else if (div_rsp.done) begin
                        if (top_zero) begin
                            r_result <= r_total;
                            r_valid  <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            // Next cycle forms n*top, the one after adds it
                            r_top <= div_rsp.quo[31:0];
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // The reflection product: r_top is written on the quotient cycle, the
    // multiplier forms n*top the cycle after (default operand arm), and
    // r_refl_acc marks the cycle in which r_prod holds it.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_wait <= 1'b0;
        end else begin
            r_mul_wait <= (r_state == S_F_DIV) && !r_refl_acc && div_rsp.done && !top_zero;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_floor_total = r_result;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_Z_DIV || r_state == S_R_DIVA ||
                          r_state == S_R_DIVB || r_state == S_F_DIV))
        else $error("divider finished outside a wait state");
`endif

endmodule
